>>> hdl/ffa_pkg.sv
package ffa_pkg;

  localparam int ADDR_W = 12;
  localparam int SIZE_W = 12;
  localparam int OP_W = 2;
  localparam int ST_W = 2;
  localparam int NEED_W = SIZE_W + 1;

  localparam int DEF_ARENA_UNITS = 4096;
  localparam int DEF_MAX_FREE = 64;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE = 2'd1;
  localparam logic [OP_W-1:0] OP_REALLOC = 2'd2;

  localparam logic [ST_W-1:0] ST_OK = 2'd0;
  localparam logic [ST_W-1:0] ST_NOFIT = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic            init;
    logic            load;
    logic            lrd;
    logic            scan_start;
    logic            scan_run;
    logic            free_mode;
    logic            a_take;
    logic            shd_start;
    logic            shu_start;
    logic            sh_run;
    logic            sh_up;
    logic            cnt_dec;
    logic            f_merge;
    logic            ins;
    logic            addr_p;
    logic            set_st;
    logic [ST_W-1:0] st_val;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            p_zero;
    logic            p_oob;
    logic            len_ok;
    logic            len_bad;
    logic            hit;
    logic            scan_end;
    logic            whole;
    logic            sh_end;
    logic            ovl;
    logic            mp;
    logic            mn;
    logic            full;
  } sts_t;

endpackage

>>> hdl/first_fit_free_list_allocator.sv
// One request at a time; an allocate and a free each scan the table entries, and the next word
// is accepted once busy has fallen again. Table entries are moved when a whole segment is
// taken, when a free merges two segments into one, or when a free inserts a new segment.
// A reallocate that moves its block does an allocate and then a free of the old block.
// After reset the block is busy while the table is set to one free segment.
// Each result word is shown for one cycle with done_o; the receiver cannot stall.
module first_fit_free_list_allocator #(
  parameter int ARENA_UNITS = ffa_pkg::DEF_ARENA_UNITS,
  parameter int MAX_FREE = ffa_pkg::DEF_MAX_FREE
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [ffa_pkg::OP_W-1:0]   operation_i,
  input  logic [ffa_pkg::SIZE_W-1:0] request_size_i,
  input  logic [ffa_pkg::ADDR_W-1:0] block_address_i,
  output logic                       done_o,
  output logic [ffa_pkg::ADDR_W-1:0] result_address_o,
  output logic [ffa_pkg::ST_W-1:0]   status_o
);
  import ffa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ffa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  ffa_dp #(
    .ARENA_UNITS (ARENA_UNITS),
    .MAX_FREE    (MAX_FREE)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .operation_i      (operation_i),
    .request_size_i   (request_size_i),
    .block_address_i  (block_address_i),
    .result_address_o (result_address_o),
    .status_o         (status_o)
  );

endmodule

>>> hdl/ffa_ctrl.sv
module ffa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  output logic          done_o,
  input  ffa_pkg::sts_t sts_i,
  output ffa_pkg::cmd_t cmd_o
);
  import ffa_pkg::*;

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DISP   = 4'd2;
  localparam logic [3:0] S_R_CHK  = 4'd3;
  localparam logic [3:0] S_A_SCAN = 4'd4;
  localparam logic [3:0] S_A_TAKE = 4'd5;
  localparam logic [3:0] S_A_SHD  = 4'd6;
  localparam logic [3:0] S_F_RD   = 4'd7;
  localparam logic [3:0] S_F_CHK  = 4'd8;
  localparam logic [3:0] S_F_SCAN = 4'd9;
  localparam logic [3:0] S_F_DEC  = 4'd10;
  localparam logic [3:0] S_F_SHD  = 4'd11;
  localparam logic [3:0] S_F_SHU  = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  logic [3:0] state_q, state_d;
  logic       then_free;

  assign then_free = (sts_i.op == OP_REALLOC) && !sts_i.p_zero;
  assign busy = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      S_INIT: begin
        cmd_o.init = 1'b1;
        state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        cmd_o.lrd = 1'b1;
        case (sts_i.op)
          OP_ALLOC: begin
            cmd_o.scan_start = 1'b1;
            state_d = S_A_SCAN;
          end
          OP_FREE: begin
            state_d = (sts_i.p_zero || sts_i.p_oob) ? S_DONE : S_F_CHK;
          end
          OP_REALLOC: begin
            if (sts_i.p_zero) begin
              cmd_o.scan_start = 1'b1;
              state_d = S_A_SCAN;
            end else if (sts_i.p_oob) begin
              state_d = S_DONE;
            end else begin
              state_d = S_R_CHK;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_R_CHK: begin
        if (sts_i.len_ok) begin
          cmd_o.addr_p = 1'b1;
          state_d = S_DONE;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d = S_A_SCAN;
        end
      end
      S_A_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (sts_i.hit) begin
          state_d = S_A_TAKE;
        end else if (sts_i.scan_end) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st_val = ST_NOFIT;
          state_d = S_DONE;
        end
      end
      S_A_TAKE: begin
        cmd_o.a_take = 1'b1;
        if (sts_i.whole) begin
          cmd_o.shd_start = 1'b1;
          state_d = S_A_SHD;
        end else begin
          state_d = then_free ? S_F_RD : S_DONE;
        end
      end
      S_A_SHD: begin
        cmd_o.sh_run = 1'b1;
        if (sts_i.sh_end) begin
          cmd_o.cnt_dec = 1'b1;
          state_d = then_free ? S_F_RD : S_DONE;
        end
      end
      S_F_RD: begin
        cmd_o.lrd = 1'b1;
        state_d = S_F_CHK;
      end
      S_F_CHK: begin
        if (sts_i.len_bad) begin
          state_d = S_DONE;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d = S_F_SCAN;
        end
      end
      S_F_SCAN: begin
        cmd_o.scan_run = 1'b1;
        cmd_o.free_mode = 1'b1;
        if (sts_i.hit || sts_i.scan_end) begin
          state_d = S_F_DEC;
        end
      end
      S_F_DEC: begin
        if (sts_i.ovl) begin
          state_d = S_DONE;
        end else if (sts_i.mp && sts_i.mn) begin
          cmd_o.f_merge = 1'b1;
          cmd_o.shd_start = 1'b1;
          state_d = S_F_SHD;
        end else if (sts_i.mp || sts_i.mn) begin
          cmd_o.f_merge = 1'b1;
          state_d = S_DONE;
        end else if (sts_i.full) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st_val = ST_FULL;
          state_d = S_DONE;
        end else begin
          cmd_o.shu_start = 1'b1;
          state_d = S_F_SHU;
        end
      end
      S_F_SHD: begin
        cmd_o.sh_run = 1'b1;
        if (sts_i.sh_end) begin
          cmd_o.cnt_dec = 1'b1;
          state_d = S_DONE;
        end
      end
      S_F_SHU: begin
        cmd_o.sh_run = 1'b1;
        cmd_o.sh_up = 1'b1;
        if (sts_i.sh_end) begin
          cmd_o.ins = 1'b1;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

>>> hdl/ffa_dp.sv
module ffa_dp #(
  parameter int ARENA_UNITS = ffa_pkg::DEF_ARENA_UNITS,
  parameter int MAX_FREE = ffa_pkg::DEF_MAX_FREE
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ffa_pkg::cmd_t              cmd_i,
  output ffa_pkg::sts_t              sts_o,
  input  logic [ffa_pkg::OP_W-1:0]   operation_i,
  input  logic [ffa_pkg::SIZE_W-1:0] request_size_i,
  input  logic [ffa_pkg::ADDR_W-1:0] block_address_i,
  output logic [ffa_pkg::ADDR_W-1:0] result_address_o,
  output logic [ffa_pkg::ST_W-1:0]   status_o
);
  import ffa_pkg::*;

  localparam int AW = $clog2(ARENA_UNITS);
  localparam int LW = $clog2(ARENA_UNITS + 1);
  localparam int IW = $clog2(MAX_FREE);
  localparam int CW = $clog2(MAX_FREE + 1);
  localparam int NW = (LW > NEED_W) ? LW : NEED_W;
  localparam int EW = AW + LW;
  localparam int MW = LW + ADDR_W;

  logic [EW-1:0] seg_mem [MAX_FREE];
  logic [LW-1:0] len_mem [ARENA_UNITS];

  logic [OP_W-1:0]   op_q;
  logic [ADDR_W-1:0] p_q;
  logic [NEED_W-1:0] need_q;
  logic [ADDR_W-1:0] addr_q;
  logic [ST_W-1:0]   status_q;
  logic [EW-1:0]     seg_rd_q;
  logic [LW-1:0]     lrd_q;
  logic [CW-1:0]     count_q, idx_q, ridx_q, i_q, r_q, w_q;
  logic              rv_q, pend_q;
  logic [AW-1:0]     cur_start_q, prev_start_q;
  logic [LW-1:0]     cur_len_q, prev_len_q;
  logic              has_prev_q, has_next_q;

  logic [MW-1:0]     pw, hdr_w, naddr_w;
  logic [AW-1:0]     hdr, rd_start, carve_hdr, take_hdr;
  logic [LW-1:0]     rd_len, rem, take_len, prev_end, hdr_l, blk_end, carve_l;
  logic              hit_now, scan_rd, sh_rd, whole, mp, mn;
  logic [CW-1:0]     im1, sh_ra;
  logic              we;
  logic [IW-1:0]     wa, ra;
  logic [EW-1:0]     wd;
  logic [NEED_W-1:0] need_d;

  assign pw = MW'(p_q);
  assign hdr_w = pw - MW'(1);
  assign hdr = hdr_w[AW-1:0];
  assign hdr_l = LW'(hdr);
  assign rd_start = seg_rd_q[EW-1:LW];
  assign rd_len = seg_rd_q[LW-1:0];
  assign rem = cur_len_q - LW'(need_q);
  assign whole = rem < LW'(3);
  assign carve_l = LW'(cur_start_q) + rem;
  assign carve_hdr = carve_l[AW-1:0];
  assign take_hdr = whole ? cur_start_q : carve_hdr;
  assign take_len = whole ? cur_len_q : LW'(need_q);
  assign naddr_w = MW'(take_hdr) + MW'(1);
  assign prev_end = LW'(prev_start_q) + prev_len_q;
  assign blk_end = hdr_l + lrd_q;
  assign mp = has_prev_q && (prev_end == hdr_l);
  assign mn = has_next_q && (blk_end == LW'(cur_start_q));
  assign im1 = i_q - CW'(1);
  assign need_d = ((request_size_i == '0) ? NEED_W'(1) : NEED_W'(request_size_i)) + NEED_W'(1);

  assign hit_now = rv_q && (cmd_i.free_mode ? (rd_start > hdr)
                                            : (NW'(rd_len) >= NW'(need_q)));
  assign scan_rd = cmd_i.scan_run && !hit_now && (idx_q < count_q);
  assign sh_rd = cmd_i.sh_run && (cmd_i.sh_up ? (r_q > i_q) : (r_q < count_q));
  assign sh_ra = cmd_i.sh_up ? (r_q - CW'(1)) : r_q;
  assign ra = scan_rd ? idx_q[IW-1:0] : sh_ra[IW-1:0];

  always_comb begin
    sts_o.op = op_q;
    sts_o.p_zero = (p_q == '0);
    sts_o.p_oob = pw >= MW'(ARENA_UNITS);
    sts_o.len_ok = NW'(lrd_q) >= NW'(need_q);
    sts_o.len_bad = (lrd_q == '0) || (lrd_q > (LW'(ARENA_UNITS) - hdr_l));
    sts_o.hit = hit_now;
    sts_o.scan_end = !rv_q && (idx_q >= count_q);
    sts_o.whole = whole;
    sts_o.sh_end = !pend_q && (cmd_i.sh_up ? (r_q <= i_q) : (r_q >= count_q));
    sts_o.ovl = (has_prev_q && (prev_end > hdr_l)) ||
                (has_next_q && (blk_end > LW'(cur_start_q)));
    sts_o.mp = mp;
    sts_o.mn = mn;
    sts_o.full = count_q >= CW'(MAX_FREE);
  end

  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = '0;
    if (cmd_i.init) begin
      we = 1'b1;
      wd = {AW'(0), LW'(ARENA_UNITS)};
    end else if (cmd_i.a_take && !whole) begin
      we = 1'b1;
      wa = i_q[IW-1:0];
      wd = {cur_start_q, rem};
    end else if (cmd_i.f_merge) begin
      we = 1'b1;
      if (mp) begin
        wa = im1[IW-1:0];
        wd = {prev_start_q, prev_len_q + lrd_q + (mn ? cur_len_q : LW'(0))};
      end else begin
        wa = i_q[IW-1:0];
        wd = {hdr, cur_len_q + lrd_q};
      end
    end else if (cmd_i.sh_run && pend_q) begin
      we = 1'b1;
      wa = w_q[IW-1:0];
      wd = seg_rd_q;
    end else if (cmd_i.ins) begin
      we = 1'b1;
      wa = i_q[IW-1:0];
      wd = {hdr, lrd_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      seg_mem[wa] <= wd;
    end
    if (scan_rd || sh_rd) begin
      seg_rd_q <= seg_mem[ra];
    end
    if (cmd_i.a_take) begin
      len_mem[take_hdr] <= take_len;
    end
    if (cmd_i.lrd) begin
      lrd_q <= len_mem[hdr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CW'(1);
      rv_q <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      if (cmd_i.init) begin
        count_q <= CW'(1);
      end else if (cmd_i.cnt_dec) begin
        count_q <= count_q - CW'(1);
      end else if (cmd_i.ins) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.scan_start) begin
        rv_q <= 1'b0;
      end else if (cmd_i.scan_run) begin
        rv_q <= scan_rd;
      end
      if (cmd_i.shd_start || cmd_i.shu_start) begin
        pend_q <= 1'b0;
      end else if (cmd_i.sh_run) begin
        pend_q <= sh_rd;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= operation_i;
      p_q <= block_address_i;
      need_q <= need_d;
      addr_q <= '0;
      status_q <= ST_OK;
    end else begin
      if (cmd_i.a_take) begin
        addr_q <= naddr_w[ADDR_W-1:0];
      end else if (cmd_i.addr_p) begin
        addr_q <= p_q;
      end
      if (cmd_i.set_st) begin
        status_q <= cmd_i.st_val;
      end
    end
    if (cmd_i.scan_start) begin
      idx_q <= '0;
      i_q <= count_q;
      has_prev_q <= 1'b0;
      has_next_q <= 1'b0;
    end else if (cmd_i.scan_run) begin
      if (scan_rd) begin
        idx_q <= idx_q + CW'(1);
        ridx_q <= idx_q;
      end
      if (hit_now) begin
        cur_start_q <= rd_start;
        cur_len_q <= rd_len;
        i_q <= ridx_q;
        has_next_q <= 1'b1;
      end else if (cmd_i.free_mode && rv_q) begin
        prev_start_q <= rd_start;
        prev_len_q <= rd_len;
        has_prev_q <= 1'b1;
      end
    end
    if (cmd_i.shd_start) begin
      r_q <= i_q + CW'(1);
      w_q <= i_q;
    end else if (cmd_i.shu_start) begin
      r_q <= count_q;
      w_q <= count_q;
    end else if (cmd_i.sh_run) begin
      if (sh_rd) begin
        r_q <= cmd_i.sh_up ? (r_q - CW'(1)) : (r_q + CW'(1));
      end
      if (pend_q) begin
        w_q <= cmd_i.sh_up ? (w_q - CW'(1)) : (w_q + CW'(1));
      end
    end
  end

  assign result_address_o = addr_q;
  assign status_o = status_q;

endmodule

>>> test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ffa_pkg::*;

  localparam int ARENA = DEF_ARENA_UNITS;
  localparam int TABLE_DEPTH = DEF_MAX_FREE;
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;
  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [ST_W-1:0]   st;
  } word_t;

  class ffa_scoreboard;
    int seg_base[TABLE_DEPTH];
    int seg_size[TABLE_DEPTH];
    int seg_count;
    int hdr_len[ARENA];
    bit hdr_known[ARENA];
    int known_addrs[$];
    int live[$];
    word_t pending[$];
    int errors;

    function new();
      seg_base[0] = 0;
      seg_size[0] = ARENA;
      seg_count = 1;
      errors = 0;
    endfunction

    function void drop_seg(int i);
      for (int j = i; j + 1 < seg_count; j++) begin
        seg_base[j] = seg_base[j+1];
        seg_size[j] = seg_size[j+1];
      end
      seg_count--;
    endfunction

    function void forget_live(int p);
      foreach (live[k]) begin
        if (live[k] == p) begin
          live.delete(k);
          return;
        end
      end
    endfunction

    function logic [ST_W-1:0] carve(int size, output int addr);
      int need;
      int hdr;
      int blen;
      need = (size == 0 ? 1 : size) + 1;
      addr = 0;
      for (int i = 0; i < seg_count; i++) begin
        if (seg_size[i] >= need) begin
          if (seg_size[i] - need < 3) begin
            hdr = seg_base[i];
            blen = seg_size[i];
            drop_seg(i);
          end else begin
            seg_size[i] -= need;
            hdr = seg_base[i] + seg_size[i];
            blen = need;
          end
          hdr_len[hdr] = blen;
          if (!hdr_known[hdr]) begin
            hdr_known[hdr] = 1'b1;
            known_addrs.push_back(hdr + 1);
          end
          addr = hdr + 1;
          return ST_OK;
        end
      end
      return ST_NOFIT;
    endfunction

    function logic [ST_W-1:0] release_block(int p);
      int hdr;
      int blen;
      int i;
      bit hp;
      bit hn;
      bit mp;
      bit mn;
      if (p == 0 || p >= ARENA) return ST_OK;
      hdr = p - 1;
      blen = hdr_len[hdr];
      if (blen == 0 || blen > ARENA - hdr) return ST_OK;
      i = 0;
      while (i < seg_count && seg_base[i] <= hdr) i++;
      hp = i > 0;
      hn = i < seg_count;
      if (hp && seg_base[i-1] + seg_size[i-1] > hdr) return ST_OK;
      if (hn && hdr + blen > seg_base[i]) return ST_OK;
      mp = hp && seg_base[i-1] + seg_size[i-1] == hdr;
      mn = hn && hdr + blen == seg_base[i];
      if (mp && mn) begin
        seg_size[i-1] += blen + seg_size[i];
        drop_seg(i);
      end else if (mp) begin
        seg_size[i-1] += blen;
      end else if (mn) begin
        seg_base[i] = hdr;
        seg_size[i] += blen;
      end else begin
        if (seg_count >= TABLE_DEPTH) return ST_FULL;
        for (int j = seg_count; j > i; j--) begin
          seg_base[j] = seg_base[j-1];
          seg_size[j] = seg_size[j-1];
        end
        seg_base[i] = hdr;
        seg_size[i] = blen;
        seg_count++;
      end
      return ST_OK;
    endfunction

    function void note(logic [OP_W-1:0] op, int size, int p);
      word_t w;
      int a;
      int need;
      a = 0;
      w.st = ST_OK;
      case (op)
        OP_ALLOC: begin
          w.st = carve(size, a);
          if (w.st == ST_OK) live.push_back(a);
        end
        OP_FREE: begin
          w.st = release_block(p);
          if (w.st == ST_OK) forget_live(p);
        end
        OP_REALLOC: begin
          need = (size == 0 ? 1 : size) + 1;
          if (p == 0) begin
            w.st = carve(size, a);
            if (w.st == ST_OK) live.push_back(a);
          end else if (hdr_len[p-1] >= need) begin
            a = p;
          end else begin
            w.st = carve(size, a);
            if (w.st == ST_OK) begin
              live.push_back(a);
              w.st = release_block(p);
              if (w.st == ST_OK) forget_live(p);
            end
          end
        end
        default: ;
      endcase
      w.addr = a[ADDR_W-1:0];
      pending.push_back(w);
    endfunction

    task report(string what, int got, int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      errors++;
    endtask

    task check(logic [ADDR_W-1:0] addr, logic [ST_W-1:0] st);
      word_t w;
      if (pending.size() == 0) begin
        report("unexpected word, address", addr, -1);
        return;
      end
      w = pending.pop_front();
      if (addr !== w.addr) report("result address", addr, w.addr);
      if (st !== w.st) report("status", st, w.st);
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  logic [OP_W-1:0] operation_i;
  logic [SIZE_W-1:0] request_size_i;
  logic [ADDR_W-1:0] block_address_i;
  logic done_o;
  logic [ADDR_W-1:0] result_address_o;
  logic [ST_W-1:0] status_o;

  ffa_scoreboard sb;
  int idle_cycles = 0;

  first_fit_free_list_allocator dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .operation_i(operation_i),
    .request_size_i(request_size_i),
    .block_address_i(block_address_i),
    .done_o(done_o),
    .result_address_o(result_address_o),
    .status_o(status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check(result_address_o, status_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || done_o || (start && !busy)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL first_fit_free_list_allocator");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic issue(logic [OP_W-1:0] op, int size, int p, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    operation_i <= op;
    request_size_i <= size[SIZE_W-1:0];
    block_address_i <= p[ADDR_W-1:0];
    do @(posedge clk_i); while (busy);
    sb.note(op, size, p);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic send(logic [OP_W-1:0] op, int size, int p);
    issue(op, size, p, pick_gap());
  endtask

  task automatic free_all();
    int snap[$];
    snap = sb.live;
    foreach (snap[k]) send(OP_FREE, 0, snap[k]);
  endtask

  function automatic int any_live();
    if (sb.live.size() == 0) return 0;
    return sb.live[$urandom_range(0, sb.live.size() - 1)];
  endfunction

  task automatic random_word();
    int r;
    int p;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      send(OP_ALLOC, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                                 : $urandom_range(0, 40), 0);
    end else if (r < 75) begin
      p = any_live();
      if ($urandom_range(0, 19) == 0 && sb.known_addrs.size() != 0)
        p = sb.known_addrs[$urandom_range(0, sb.known_addrs.size() - 1)];
      send(OP_FREE, $urandom_range(0, 4095), p);
    end else if (r < 90) begin
      send(OP_REALLOC, $urandom_range(0, 60), any_live());
    end else if (r < 95) begin
      send(OP_NONE, $urandom_range(0, 4095), $urandom_range(0, 4095));
    end else begin
      send(OP_REALLOC, $urandom_range(0, 30), 0);
    end
  endtask

  task automatic fragment();
    int got[$];
    for (int k = 0; k < 140; k++) begin
      send(OP_ALLOC, $urandom_range(0, 1), 0);
      if (sb.pending[$].st == ST_OK) got.push_back(sb.pending[$].addr);
    end
    for (int k = 0; k < got.size(); k += 2) send(OP_FREE, 0, got[k]);
    for (int k = 1; k < got.size(); k += 2) send(OP_FREE, 0, got[k]);
  endtask

  initial begin
    int a;
    sb = new();
    rst_ni <= 1'b0;
    start <= 1'b0;
    operation_i <= OP_ALLOC;
    request_size_i <= '0;
    block_address_i <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    send(OP_ALLOC, 0, 0);
    send(OP_ALLOC, 4095, 0);
    send(OP_ALLOC, 4094, 0);
    send(OP_ALLOC, 100, 0);
    send(OP_FREE, 0, 4095);
    send(OP_FREE, 0, 4095);
    send(OP_FREE, 4095, 0);
    send(OP_NONE, 4095, 4095);
    send(OP_REALLOC, 5, 0);
    a = sb.live[$];
    send(OP_REALLOC, 0, a);
    send(OP_REALLOC, 200, a);
    send(OP_REALLOC, 4095, sb.live[$]);
    send(OP_ALLOC, 1000, 0);
    send(OP_ALLOC, 2000, 0);
    send(OP_ALLOC, 2000, 0);
    free_all();
    drain();

    for (int n = 0; n < 750; n++) begin
      if (n == 100) fragment();
      if (n == 500) drain();
      if (n % 300 == 299) free_all();
      random_word();
    end
    drain();
    repeat (400) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS first_fit_free_list_allocator");
    end else begin
      $display("FAIL first_fit_free_list_allocator");
    end
    $finish;
  end
endmodule
